// ===== rtl/lxr_pkg.sv =====
// Shared types, sizes and character helpers for the keyword token lexer.
// Used by every file under rtl/; depends on nothing else.
package lxr_pkg;

  localparam int TEXT_BYTES  = 128;
  localparam int CHUNK_BYTES = 8;
  localparam int ROWS        = (TEXT_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LANE_W      = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
  localparam int CNT_W       = $clog2(TEXT_BYTES + 1);
  localparam int CHUNK_W     = CHUNK_BYTES * 8;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int KIND_W      = 4;
  localparam int TEXT_OUT_W  = 64;
  localparam int CBYTES_W    = 4;
  localparam int TLEN_W      = 8;
  localparam int S_TDATA_W   = 8;
  localparam int M_TDATA_W   = 80;
  localparam int M_TUSER_W   = 8;

  localparam int LEN_DEFINE = 6;
  localparam int LEN_FUNC   = 4;
  localparam int LEN_PRINT  = 5;

  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [KIND_W-1:0] {
    K_DEFINE  = 4'd0,
    K_FUNC    = 4'd1,
    K_PRINT   = 4'd2,
    K_IDENT   = 4'd3,
    K_NUMBER  = 4'd4,
    K_STRING  = 4'd5,
    K_EQ      = 4'd6,
    K_SEMI    = 4'd7,
    K_LPAREN  = 4'd8,
    K_RPAREN  = 4'd9,
    K_LBRACE  = 4'd10,
    K_RBRACE  = 4'd11,
    K_UNKNOWN = 4'd12
  } kind_t;

  // One token to be sent by the back end.
  typedef struct packed {
    kind_t            kind;
    logic [CNT_W-1:0] len;
    logic             trunc;
    logic             from_store;
    logic [7:0]       ch;
    logic             lor;
  } job_t;

  // Byte write into the text store.
  typedef struct packed {
    logic              en;
    logic [ROW_W-1:0]  row;
    logic [LANE_W-1:0] lane;
    logic [7:0]        data;
  } wr_t;

  // Back-end status seen by the front end.
  typedef struct packed {
    logic busy;
    logic done;
  } bk_st_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || c == CH_UNDER;
  endfunction

  function automatic kind_t punct_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_EQ:     k = K_EQ;
      CH_SEMI:   k = K_SEMI;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      default:   k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] define_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = "d";
      3'd1:    r = "e";
      3'd2:    r = "f";
      3'd3:    r = "i";
      3'd4:    r = "n";
      3'd5:    r = "e";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] func_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = "f";
      3'd1:    r = "u";
      3'd2:    r = "n";
      3'd3:    r = "c";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] print_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0:    r = "p";
      3'd1:    r = "r";
      3'd2:    r = "i";
      3'd3:    r = "n";
      3'd4:    r = "t";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/keyword_token_lexer.sv =====
// Top level of the keyword token lexer: front end, token queue and back end.
// Depends on lxr_pkg, lxr_front, lxr_job_fifo and lxr_back.
//
// Usage. Source text enters on the s_ stream, one byte per beat in
// s_tdata[7:0]; a beat with s_tlast high is the end mark, its data byte is
// ignored and it closes whatever token is open. Tokens leave on the m_ stream
// as chunks of up to eight text bytes; each token gives one or more beats and
// m_tlast marks its final chunk. Identifiers are checked against the
// keywords define, func and print when they close.
//
// Timing. A byte that extends or opens a token is taken at once. A byte that
// closes an identifier or number is held while its token is queued, then
// taken again from idle, unless it is whitespace. Input stalls while a stored
// token is being sent, because the next token reuses the text store; such a
// token has its first row read before its first beat and then gives one beat
// per cycle, set by the single read port of the store (one 8-byte row per
// cycle). Single-character tokens come straight from the four-entry queue,
// one beat per cycle, and do not hold up the input. If the receiver stalls,
// the output register holds its beat, the queue fills, then s_tready falls.
//
// Reset clears the scan state, the queue and the output; the text store is
// not cleared, as only bytes already written are ever sent.
module keyword_token_lexer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [lxr_pkg::S_TDATA_W-1:0]  s_tdata,   // [7:0] char_in
  input  logic                           s_tlast,   // end_of_text
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [63:0] text_chunk, [67:64] chunk_bytes, [75:68] token_length,
  // [76] last_of_run, [79:77] zero
  output logic [lxr_pkg::M_TDATA_W-1:0]  m_tdata,
  // [3:0] token_kind, [4] text_truncated, [7:5] zero
  output logic [lxr_pkg::M_TUSER_W-1:0]  m_tuser,
  output logic                           m_tlast    // last_chunk
);
  import lxr_pkg::*;

  // Tokens travel from the front end to the back end through a short queue,
  // so punctuation can keep flowing while the output is stalled.
  logic   push, q_full, q_valid, pop;
  job_t   job, head;
  wr_t    wr;
  bk_st_t bk_st;

  lxr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .job      (job),
    .wr       (wr),
    .bk_st    (bk_st)
  );

  lxr_job_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (job),
    .full  (q_full),
    .pop   (pop),
    .valid (q_valid),
    .dout  (head)
  );

  // The back end owns the text store; the front end writes into it directly.
  lxr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .wr       (wr),
    .bk_st    (bk_st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // The store must never be written while a stored token is being read out.
  a_no_write_while_reading : assert property (@(posedge clk) disable iff (rst)
    wr.en |-> !bk_st.busy)
    else $error("text store written during readout");

  // A chunk that is not the last of its token is always full.
  a_full_inner_chunk : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[67:64] == CBYTES_W'(CHUNK_BYTES)))
    else $error("short chunk before end of token");

  // The last beat of a byte's results always closes a token.
  a_run_ends_token : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[76]) |-> m_tlast)
    else $error("last_of_run on an inner chunk");

  // A full queue is never pushed.
  a_no_overflow_push : assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("token queue pushed while full");

endmodule

// ===== rtl/lxr_front.sv =====
// Front end of the lexer: accepts source bytes, tracks the open token, writes
// its text into the back end's store and queues tokens. Depends on lxr_pkg.
module lxr_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [lxr_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic                           s_tlast,
  input  logic                           q_full,
  output logic                           push,
  output lxr_pkg::job_t                  job,
  output lxr_pkg::wr_t                   wr,
  input  lxr_pkg::bk_st_t                bk_st
);
  import lxr_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_IDENT, M_NUMBER, M_STRING} mode_t;

  mode_t              mode, mode_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               ovf, ovf_next;
  logic [ROW_W-1:0]   row, row_next;
  logic [LANE_W-1:0]  lane, lane_next;
  logic               m_def, m_def_next, m_func, m_func_next, m_print, m_print_next;
  logic [QCNT_W-1:0]  pend, pend_next;

  logic [7:0]         c;
  logic               do_append, do_start, cont;
  logic [CNT_W-1:0]   b_count;
  logic [ROW_W-1:0]   b_row;
  logic [LANE_W-1:0]  b_lane;
  logic               b_def, b_func, b_print;
  kind_t              close_kind;
  job_t               close_job;

  assign c = s_tdata[7:0];

  always_comb begin
    if (mode == M_IDENT) begin
      if (!ovf && count == CNT_W'(LEN_DEFINE) && m_def) close_kind = K_DEFINE;
      else if (!ovf && count == CNT_W'(LEN_FUNC) && m_func) close_kind = K_FUNC;
      else if (!ovf && count == CNT_W'(LEN_PRINT) && m_print) close_kind = K_PRINT;
      else close_kind = K_IDENT;
    end else if (mode == M_NUMBER) begin
      close_kind = K_NUMBER;
    end else begin
      close_kind = K_STRING;
    end
    close_job            = '0;
    close_job.kind       = close_kind;
    close_job.len        = count;
    close_job.trunc      = ovf;
    close_job.from_store = 1'b1;
    close_job.lor        = 1'b1;
  end

  always_comb begin
    s_tready  = 1'b0;
    push      = 1'b0;
    job       = close_job;
    do_append = 1'b0;
    do_start  = 1'b0;
    mode_next = mode;
    cont      = (mode == M_IDENT) ? is_ident_char(c) : is_digit(c);
    if (s_tvalid && !q_full) begin
      if (s_tlast) begin
        s_tready  = 1'b1;
        mode_next = M_IDLE;
        push      = (mode != M_IDLE);
      end else begin
        case (mode)
          M_STRING: begin
            if (c == CH_QUOTE) begin
              s_tready  = 1'b1;
              push      = 1'b1;
              mode_next = M_IDLE;
            end else if (pend == '0) begin
              s_tready  = 1'b1;
              do_append = 1'b1;
            end
          end
          M_IDENT, M_NUMBER: begin
            if (cont) begin
              if (pend == '0) begin
                s_tready  = 1'b1;
                do_append = 1'b1;
              end
            end else begin
              // Close the token; the byte itself is taken again from idle
              // unless it is whitespace.
              push      = 1'b1;
              mode_next = M_IDLE;
              if (is_space(c)) begin
                s_tready = 1'b1;
              end else if (!(is_letter(c) || is_digit(c) || c == CH_QUOTE)) begin
                job.lor = 1'b0;
              end
            end
          end
          default: begin
            if (is_space(c)) begin
              s_tready = 1'b1;
            end else if (is_letter(c) || is_digit(c)) begin
              if (pend == '0) begin
                s_tready  = 1'b1;
                do_start  = 1'b1;
                do_append = 1'b1;
                mode_next = is_letter(c) ? M_IDENT : M_NUMBER;
              end
            end else if (c == CH_QUOTE) begin
              s_tready  = 1'b1;
              do_start  = 1'b1;
              mode_next = M_STRING;
            end else begin
              s_tready       = 1'b1;
              push           = 1'b1;
              job            = '0;
              job.kind       = punct_kind(c);
              job.len        = CNT_W'(1);
              job.ch         = c;
              job.lor        = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    b_count = do_start ? '0 : count;
    b_row   = do_start ? '0 : row;
    b_lane  = do_start ? '0 : lane;
    b_def   = do_start | m_def;
    b_func  = do_start | m_func;
    b_print = do_start | m_print;

    count_next   = b_count;
    row_next     = b_row;
    lane_next    = b_lane;
    ovf_next     = do_start ? 1'b0 : ovf;
    m_def_next   = b_def;
    m_func_next  = b_func;
    m_print_next = b_print;
    wr           = '0;
    if (do_append) begin
      if (b_count < CNT_W'(TEXT_BYTES)) begin
        wr.en      = 1'b1;
        wr.row     = b_row;
        wr.lane    = b_lane;
        wr.data    = c;
        count_next = b_count + CNT_W'(1);
        if (b_lane == LANE_W'(CHUNK_BYTES - 1)) begin
          lane_next = '0;
          row_next  = b_row + ROW_W'(1);
        end else begin
          lane_next = b_lane + LANE_W'(1);
        end
        m_def_next   = b_def && b_count < CNT_W'(LEN_DEFINE)
                       && c == define_char(b_count[2:0]);
        m_func_next  = b_func && b_count < CNT_W'(LEN_FUNC)
                       && c == func_char(b_count[2:0]);
        m_print_next = b_print && b_count < CNT_W'(LEN_PRINT)
                       && c == print_char(b_count[2:0]);
      end else begin
        ovf_next = 1'b1;
      end
    end
    pend_next = pend + QCNT_W'(push && job.from_store) - QCNT_W'(bk_st.done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_IDLE;
      count   <= '0;
      ovf     <= 1'b0;
      pend    <= '0;
      row     <= '0;
      lane    <= '0;
      m_def   <= 1'b0;
      m_func  <= 1'b0;
      m_print <= 1'b0;
    end else begin
      mode    <= mode_next;
      count   <= count_next;
      ovf     <= ovf_next;
      pend    <= pend_next;
      row     <= row_next;
      lane    <= lane_next;
      m_def   <= m_def_next;
      m_func  <= m_func_next;
      m_print <= m_print_next;
    end
  end

endmodule

// ===== rtl/lxr_job_fifo.sv =====
// Short token queue between the front and back ends of the lexer.
// Depends on lxr_pkg for the entry type and depth.
module lxr_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lxr_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output lxr_pkg::job_t dout
);
  import lxr_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] cnt;

  assign full  = (cnt == QCNT_W'(QDEPTH));
  assign valid = (cnt != '0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push && !full) wptr <= wptr + QPTR_W'(1);
      if (pop && valid) rptr <= rptr + QPTR_W'(1);
      cnt <= cnt + QCNT_W'(push && !full) - QCNT_W'(pop && valid);
    end
  end

endmodule

// ===== rtl/lxr_back.sv =====
// Back end of the lexer: holds the token text store and turns queued tokens
// into output chunks, one row of the store per beat. Depends on lxr_pkg.
module lxr_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  lxr_pkg::job_t                  head,
  output logic                           pop,
  input  lxr_pkg::wr_t                   wr,
  output lxr_pkg::bk_st_t                bk_st,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [lxr_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic [lxr_pkg::M_TUSER_W-1:0]  m_tuser,
  output logic                           m_tlast
);
  import lxr_pkg::*;

  typedef enum logic {B_IDLE, B_READ} bstate_t;

  logic [CHUNK_W-1:0] mem [ROWS];
  logic [CHUNK_W-1:0] rd_data;
  logic               rd_en;
  logic [ROW_W-1:0]   rd_addr;

  bstate_t            state;
  logic [CNT_W-1:0]   rem;
  logic [ROW_W-1:0]   rd_row;

  logic                  out_free, ld, last;
  logic [CNT_W-1:0]      take;
  logic [CHUNK_W-1:0]    masked;
  kind_t                 n_kind;
  logic [TEXT_OUT_W-1:0] n_chunk;
  logic [CBYTES_W-1:0]   n_bytes;
  logic [TLEN_W-1:0]     n_len;
  logic                  n_trunc, n_last, n_lor;

  kind_t                 o_kind;
  logic [TEXT_OUT_W-1:0] o_chunk;
  logic [CBYTES_W-1:0]   o_bytes;
  logic [TLEN_W-1:0]     o_len;
  logic                  o_trunc, o_lor;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.row][wr.lane * 8 +: 8] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    out_free = !m_tvalid || m_tready;
    last     = rem <= CNT_W'(CHUNK_BYTES);
    take     = last ? rem : CNT_W'(CHUNK_BYTES);
    for (int b = 0; b < CHUNK_BYTES; b++) begin
      masked[b * 8 +: 8] = (CNT_W'(b) < take) ? rd_data[b * 8 +: 8] : 8'h00;
    end

    pop     = 1'b0;
    rd_en   = 1'b0;
    rd_addr = rd_row + ROW_W'(1);
    ld      = 1'b0;
    n_kind  = head.kind;
    n_chunk = TEXT_OUT_W'(masked);
    n_bytes = CBYTES_W'(take);
    n_len   = TLEN_W'(head.len);
    n_trunc = head.trunc;
    n_last  = last;
    n_lor   = last && head.lor;
    case (state)
      B_IDLE: begin
        if (q_valid && out_free) begin
          if (!head.from_store || head.len == '0) begin
            // Single-byte tokens carry their byte; empty strings carry none.
            ld      = 1'b1;
            pop     = 1'b1;
            n_chunk = head.from_store ? '0 : TEXT_OUT_W'(head.ch);
            n_bytes = head.from_store ? '0 : CBYTES_W'(1);
            n_last  = 1'b1;
            n_lor   = head.lor;
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
        end
      end
      B_READ: begin
        if (out_free) begin
          ld = 1'b1;
          if (last) begin
            pop = 1'b1;
          end else begin
            rd_en = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    bk_st.busy = (state == B_READ);
    bk_st.done = pop && head.from_store;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
      rem      <= '0;
      rd_row   <= '0;
    end else begin
      if (ld) begin
        m_tvalid <= 1'b1;
        o_kind   <= n_kind;
        o_chunk  <= n_chunk;
        o_bytes  <= n_bytes;
        o_len    <= n_len;
        o_trunc  <= n_trunc;
        m_tlast  <= n_last;
        o_lor    <= n_lor;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (rd_en) begin
            state  <= B_READ;
            rem    <= head.len;
            rd_row <= '0;
          end
        end
        B_READ: begin
          if (ld) begin
            if (last) begin
              state <= B_IDLE;
            end else begin
              rem    <= rem - CNT_W'(CHUNK_BYTES);
              rd_row <= rd_addr;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {3'b000, o_lor, o_len, o_bytes, o_chunk};
  assign m_tuser = {3'b000, o_trunc, o_kind};

endmodule

// ===== dv/keyword_token_lexer_test.sv =====
// Self-checking testbench for keyword_token_lexer: streams source text and end
// marks through the lexer and checks every output chunk against its own
// token predictor. Depends on lxr_pkg and rtl/keyword_token_lexer.sv.
`timescale 1ns / 1ps

module keyword_token_lexer_test;
  import lxr_pkg::*;

  localparam int TEXT_LIMIT = 128;   // bytes of token text kept before cutting
  localparam int LANES      = 8;     // text bytes per output chunk
  localparam int SETTLE     = 40;    // cycles allowed for the block to drain
  localparam logic [7:0] QUOTE = 8'h22;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUMBER, SCAN_QUOTED} scan_t;

  // One expected output chunk, unpacked from the m_ stream.
  typedef struct packed {
    kind_t       kind;
    logic [63:0] text;
    logic [3:0]  nbytes;
    logic [7:0]  tok_len;
    logic        cut;      // text was longer than the store
    logic        tail;     // final chunk of the token
    logic        run_end;  // final chunk caused by one input byte
  } chunk_t;

  // One source byte waiting to be sent, with the idle cycles placed before it.
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic [4:0] gap;
  } src_byte_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;  // [7:0] char_in
  logic                  s_tlast = 1'b0;  // end_of_text
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [63:0] text_chunk, [67:64] chunk_bytes, [75:68] token_length,
  // [76] last_of_run, [79:77] zero
  logic [M_TDATA_W-1:0]  m_tdata;
  // [3:0] token_kind, [4] text_truncated, [7:5] zero
  logic [M_TUSER_W-1:0]  m_tuser;
  logic                  m_tlast;  // last_chunk

  keyword_token_lexer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // The run must end well inside this; a hang is a failure.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Token predictor. It keeps its own copy of the scan state and of the text
  // store, and turns every accepted source beat into the chunks it must cause.
  // ---------------------------------------------------------------------------
  scan_t      scan = SCAN_IDLE;
  logic [7:0] token_text [TEXT_LIMIT];
  int         text_len = 0;
  logic       cut = 1'b0;
  chunk_t     due_chunks [$];   // chunks predicted but not yet seen
  chunk_t     held;             // newest chunk of the current beat
  bit         held_ok = 1'b0;

  function automatic bit letter_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void store_byte(input logic [7:0] c);
    if (text_len < TEXT_LIMIT) begin
      token_text[text_len] = c;
      text_len++;
    end else begin
      cut = 1'b1;
    end
  endfunction

  // A cut identifier can never be a keyword, as its length is then the limit.
  function automatic bit spells(input string w);
    if (cut || text_len != w.len()) return 1'b0;
    for (int i = 0; i < w.len(); i++)
      if (token_text[i] != w[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Splits the stored text into chunks. The newest chunk is held back so that
  // the end of the beat can mark it as the last one of the run.
  function automatic void emit_chunks(input kind_t k);
    int     pos;
    int     take;
    chunk_t r;
    pos = 0;
    do begin
      take = text_len - pos;
      if (take > LANES) take = LANES;
      r = '0;
      r.kind = k;
      for (int b = 0; b < take; b++) r.text[8*b +: 8] = token_text[pos + b];
      pos += take;
      r.nbytes  = take[3:0];
      r.tok_len = text_len[7:0];
      r.cut     = cut;
      r.tail    = (pos >= text_len);
      if (held_ok) due_chunks.push_back(held);
      held    = r;
      held_ok = 1'b1;
    end while (pos < text_len);
  endfunction

  function automatic void close_token();
    kind_t k;
    case (scan)
      SCAN_WORD: begin
        if (spells("define")) k = K_DEFINE;
        else if (spells("func")) k = K_FUNC;
        else if (spells("print")) k = K_PRINT;
        else k = K_IDENT;
      end
      SCAN_NUMBER: k = K_NUMBER;
      default:     k = K_STRING;
    endcase
    emit_chunks(k);
    scan = SCAN_IDLE;
  endfunction

  function automatic void lex_byte(input logic [7:0] c, input logic eot);
    kind_t k;
    if (eot) begin
      // The data byte of an end mark carries nothing.
      if (scan != SCAN_IDLE) close_token();
    end else if (scan == SCAN_QUOTED) begin
      // Quotes delimit the string but are not part of its text.
      if (c == QUOTE) close_token();
      else store_byte(c);
    end else if (scan == SCAN_WORD && (letter_char(c) || digit_char(c) || c == "_")) begin
      store_byte(c);
    end else if (scan == SCAN_NUMBER && digit_char(c)) begin
      store_byte(c);
    end else begin
      // A byte that ends a word or number is then scanned afresh from idle.
      if (scan != SCAN_IDLE) close_token();
      if (c == " " || (c >= 8'h09 && c <= 8'h0D)) begin
      end else if (letter_char(c) || digit_char(c)) begin
        scan     = letter_char(c) ? SCAN_WORD : SCAN_NUMBER;
        text_len = 0;
        cut      = 1'b0;
        store_byte(c);
      end else if (c == QUOTE) begin
        scan     = SCAN_QUOTED;
        text_len = 0;
        cut      = 1'b0;
      end else begin
        case (c)
          "=":     k = K_EQ;
          ";":     k = K_SEMI;
          "(":     k = K_LPAREN;
          ")":     k = K_RPAREN;
          "{":     k = K_LBRACE;
          "}":     k = K_RBRACE;
          default: k = K_UNKNOWN;
        endcase
        text_len = 0;
        cut      = 1'b0;
        store_byte(c);
        emit_chunks(k);
      end
    end
    if (held_ok) begin
      held.run_end = 1'b1;
      due_chunks.push_back(held);
      held_ok = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Source side. The stimulus block fills pending_bytes; the driver below
  // offers them in order, waiting out each byte's gap first.
  // ---------------------------------------------------------------------------
  src_byte_t pending_bytes [$];
  int        items_total = 0;
  int        items_taken = 0;
  int        tx_calm = 0;

  // Gaps come in bursty phases, with runs of back-to-back beats in between.
  function automatic void queue_byte(input logic [7:0] c, input logic eot);
    src_byte_t s;
    int        r;
    s.ch  = c;
    s.eot = eot;
    if (tx_calm > 0) begin
      tx_calm--;
      s.gap = '0;
    end else begin
      r = $urandom_range(0, 31);
      if (r == 0) tx_calm = $urandom_range(10, 40);
      s.gap = (r < 8) ? 5'($urandom_range(0, 16)) : (r < 14) ? 5'($urandom_range(0, 2)) : 5'd0;
    end
    pending_bytes.push_back(s);
    items_total++;
  endfunction

  function automatic void queue_text(input string w);
    for (int i = 0; i < w.len(); i++) queue_byte(w[i], 1'b0);
  endfunction

  function automatic void queue_blank();
    int n;
    n = $urandom_range(8, 13);
    queue_byte((n == 8) ? " " : 8'(n), 1'b0);
  endfunction

  function automatic logic [7:0] word_byte(input bit lead);
    int r;
    r = $urandom_range(0, lead ? 51 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  always @(posedge clk) begin : source_driver
    src_byte_t cur;
    bit        loaded;
    int        tx_gap;
    bit        offering;
    if (rst) begin
      s_tvalid <= 1'b0;
      loaded = 1'b0;
    end else begin
      offering = s_tvalid;
      if (s_tvalid && s_tready) begin
        lex_byte(s_tdata, s_tlast);
        items_taken++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (!loaded && pending_bytes.size() > 0) begin
          cur    = pending_bytes.pop_front();
          loaded = 1'b1;
          tx_gap = cur.gap;
        end
        if (loaded) begin
          if (tx_gap > 0) begin
            tx_gap--;
          end else begin
            s_tdata  <= cur.ch;
            s_tlast  <= cur.eot;
            offering = 1'b1;
            loaded   = 1'b0;
          end
        end
      end
      s_tvalid <= offering;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side. Each accepted beat is unpacked and compared with the oldest
  // predicted chunk; the ready line then drops for a drawn number of cycles.
  // ---------------------------------------------------------------------------
  int faults = 0;
  int beats_seen = 0;
  int rx_calm = 0;
  int hold_left = 0;
  int holds_done = 0;
  bit rx_hold = 1'b0;

  always @(posedge clk) begin : result_monitor
    chunk_t got;
    chunk_t want;
    int     rx_wait;
    int     r;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        beats_seen++;
        got.kind    = kind_t'(m_tuser[3:0]);
        got.cut     = m_tuser[4];
        got.text    = m_tdata[63:0];
        got.nbytes  = m_tdata[67:64];
        got.tok_len = m_tdata[75:68];
        got.run_end = m_tdata[76];
        got.tail    = m_tlast;
        if (due_chunks.size() == 0) begin
          if (faults < 10)
            $display("unexpected beat: kind %0d text %h bytes %0d len %0d cut %b last %b run %b",
                     got.kind, got.text, got.nbytes, got.tok_len, got.cut, got.tail,
                     got.run_end);
          faults++;
        end else begin
          want = due_chunks.pop_front();
          if (got !== want || m_tdata[79:77] !== 3'b000 || m_tuser[7:5] !== 3'b000) begin
            if (faults < 10) begin
              $display("beat %0d expected: kind %0d text %h bytes %0d len %0d cut %b last %b run %b",
                       beats_seen, want.kind, want.text, want.nbytes, want.tok_len, want.cut,
                       want.tail, want.run_end);
              $display("beat %0d actual:   kind %0d text %h bytes %0d len %0d cut %b last %b run %b pad %b %b",
                       beats_seen, got.kind, got.text, got.nbytes, got.tok_len, got.cut,
                       got.tail, got.run_end, m_tdata[79:77], m_tuser[7:5]);
            end
            faults++;
          end
        end
        // Stalls come in phases too, so that some stretches run at full rate.
        if (rx_calm > 0) begin
          rx_calm--;
          rx_wait = 0;
        end else begin
          r = $urandom_range(0, 31);
          if (r == 0) rx_calm = $urandom_range(20, 60);
          rx_wait = (r < 10) ? $urandom_range(0, 16) : (r < 16) ? 1 : 0;
        end
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      m_tready <= (rx_wait == 0) && !rx_hold;
    end
  end

  // Long receiver hold-offs. With the output stuck, the four-deep token queue
  // fills and the lexer must push back on its input while the source keeps
  // offering bytes. Counted on the falling edge so that the monitor sees a
  // settled value.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (holds_done == 0 && beats_seen >= 30) begin
      hold_left  = 300;
      holds_done = 1;
    end else if (holds_done == 1 && beats_seen >= 100) begin
      hold_left  = 150;
      holds_done = 2;
    end
    rx_hold = (hold_left > 0);
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int         r;
    int         tok_no;
    int         n;
    bit         open_end;
    string      w;
    string      puncts;
    logic [7:0] c;

    puncts = "=;(){}";

    // Directed opening. An end mark with nothing open gives no token, even
    // with a letter on the data lines. Keywords closed directly by
    // punctuation, then tab, a number closed by an underscore (which is itself
    // unknown), an ident closed by '=', an empty string, the lowest and highest
    // byte values as unknowns, and a string left open when the text ends.
    queue_byte("a", 1'b1);
    queue_text("define(func)print{");
    queue_byte(8'h09, 1'b0);
    queue_text("9_a=\"\"");
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_text(";}\"x");
    queue_byte(QUOTE, 1'b1);

    // Random part: mostly well-formed token sequences with random content,
    // some noise bytes and stray end marks. Two long tokens probe the store
    // boundary: an identifier one byte too long, closed by a semicolon (the
    // largest run a single byte can cause), and a string that fills the
    // store exactly.
    tok_no = 0;
    while (items_total < 463) begin
      if (tok_no == 12) begin
        queue_byte(" ", 1'b0);
        queue_byte(word_byte(1'b1), 1'b0);
        repeat (TEXT_LIMIT) queue_byte(word_byte(1'b0), 1'b0);
        queue_byte(";", 1'b0);
      end else if (tok_no == 30) begin
        queue_byte(QUOTE, 1'b0);
        repeat (TEXT_LIMIT) begin
          c = 8'($urandom_range(0, 255));
          queue_byte((c == QUOTE) ? 8'h27 : c, 1'b0);
        end
        queue_byte(QUOTE, 1'b0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          case ($urandom_range(0, 2))
            0:       w = "define";
            1:       w = "func";
            default: w = "print";
          endcase
          queue_text(w);
        end else if (r < 20) begin
          // Near misses of the keywords.
          case ($urandom_range(0, 9))
            0:       w = "defin";
            1:       w = "defines";
            2:       w = "Define";
            3:       w = "fun";
            4:       w = "funcs";
            5:       w = "fUnc";
            6:       w = "prin";
            7:       w = "print_";
            8:       w = "printf";
            default: w = "define1";
          endcase
          queue_text(w);
        end else if (r < 40) begin
          queue_byte(word_byte(1'b1), 1'b0);
          repeat ($urandom_range(0, 9)) queue_byte(word_byte(1'b0), 1'b0);
        end else if (r < 52) begin
          repeat ($urandom_range(1, 8)) queue_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
        end else if (r < 64) begin
          open_end = ($urandom_range(0, 7) == 0);
          queue_byte(QUOTE, 1'b0);
          n = $urandom_range(0, 14);
          repeat (n) begin
            c = 8'($urandom_range(0, 255));
            queue_byte((c == QUOTE) ? 8'h27 : c, 1'b0);
          end
          // An open string swallows everything up to the end mark.
          if (open_end) queue_byte(8'($urandom_range(0, 255)), 1'b1);
          else queue_byte(QUOTE, 1'b0);
        end else if (r < 84) begin
          queue_byte(puncts[$urandom_range(0, 5)], 1'b0);
        end else if (r < 92) begin
          queue_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (r < 96) begin
          queue_byte(8'($urandom_range(0, 255)), 1'b1);
        end else begin
          repeat ($urandom_range(1, 4)) queue_blank();
        end
      end
      // Usually a separator; without one, adjacent tokens close each other.
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 2)) queue_blank();
      tok_no++;
    end
    queue_byte(8'h00, 1'b1);

    while (items_taken < items_total) @(negedge clk);
    while (due_chunks.size() != 0 || rx_hold) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (faults == 0 && due_chunks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lxr_pkg.sv
rtl/lxr_front.sv
rtl/lxr_job_fifo.sv
rtl/lxr_back.sv
rtl/keyword_token_lexer.sv
dv/keyword_token_lexer_test.sv
